FILE: rtl/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants, types and helper functions of the 2-D median filter.
// ----------------------------------------------------------------------------
package mf2d_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_WINDOW   = 7;
   localparam int HEIGHT_LIMIT = 4096;
   localparam int QDEPTH       = 4;

   localparam int WW  = $clog2(MAX_WIDTH + 1);          // effective width
   localparam int CW  = $clog2(MAX_WIDTH);              // column index
   localparam int HTW = 13;                             // height register
   localparam int RW  = $clog2(HEIGHT_LIMIT);           // row index
   localparam int HW  = 2;                              // half window
   localparam int TW  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
   localparam int LW  = $clog2(((MAX_WINDOW - 1) / 2) * MAX_WIDTH + MAX_WINDOW);
   localparam int AW  = $clog2((MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW + QDEPTH + 4);
   localparam int NYW = RW + 2;
   localparam int NXW = CW + 2;
   localparam int DXW = $clog2(MAX_WINDOW);
   localparam int NW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int QPW = $clog2(QDEPTH);

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MODE   = 2'd2;

   typedef struct packed {
      logic [WW-1:0]  w;
      logic [HTW-1:0] h;
      logic [HW-1:0]  half;
      logic [LW-1:0]  lag;
      logic [TW-1:0]  total;
   } cfg_type;

   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic [7:0]    data;
   } store_wr_type;

   typedef struct packed {
      logic [AW-1:0] q;
      logic [RW-1:0] r;
      logic [CW-1:0] c;
      logic          last;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_TAIL,
      BK_DECIDE,
      BK_DONE
   } back_state_type;

   function automatic logic [WW-1:0] eff_width(input logic [10:0] iw);
      logic [WW-1:0] r;
      if (iw == 11'd0) r = WW'(1);
      else if (32'(iw) > MAX_WIDTH) r = WW'(MAX_WIDTH);
      else r = WW'(iw);
      return r;
   endfunction

   function automatic logic [HTW-1:0] eff_height(input logic [HTW-1:0] ih);
      logic [HTW-1:0] r;
      if (ih == '0) r = HTW'(1);
      else if (32'(ih) > HEIGHT_LIMIT) r = HTW'(HEIGHT_LIMIT);
      else r = ih;
      return r;
   endfunction

   function automatic logic [HW-1:0] eff_half(input logic [1:0] mode);
      logic [HW-1:0] h;
      h = (mode > 2'd2) ? HW'(3) : HW'(mode + 2'd1);
      if (32'(h) > (MAX_WINDOW - 1) / 2) h = HW'((MAX_WINDOW - 1) / 2);
      return h;
   endfunction

   function automatic logic [NW-1:0] win_cells(input logic [HW-1:0] half);
      logic [NW-1:0] s;
      s = NW'({half, 1'b1});
      return NW'(s * s);
   endfunction

endpackage

FILE: rtl/mf2d_queue.sv
// ----------------------------------------------------------------------------
// mf2d_queue
// Small job FIFO between the front and the back of the median filter.
// ----------------------------------------------------------------------------
module mf2d_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mf2d_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output mf2d_pkg::job_type  pop_job,
   output logic               empty
);

   mf2d_pkg::job_type entry_ff [mf2d_pkg::QDEPTH];
   logic [mf2d_pkg::QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mf2d_pkg::QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mf2d_pkg::QPW:0]   count_ff, count_in;

   assign full    = (count_ff == (mf2d_pkg::QPW+1)'(mf2d_pkg::QDEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/mf2d_front.sv
// ----------------------------------------------------------------------------
// mf2d_front
// Configuration registers, input/output position counters and item
// classification: store writes and result jobs.
// ----------------------------------------------------------------------------
module mf2d_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [12:0]            csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   action,
   input  logic [7:0]             pixel,
   input  logic                   q_full,
   output logic                   q_push,
   output mf2d_pkg::job_type      q_job,
   output mf2d_pkg::store_wr_type store_wr,
   output mf2d_pkg::cfg_type      cfg
);

   logic [10:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [1:0]  mode_ff, mode_in;
   logic        cfg_hit;
   mf2d_pkg::cfg_type cfg_ff, cfg_in;

   logic [mf2d_pkg::TW-1:0] in_count_ff, in_count_in;
   logic [mf2d_pkg::TW-1:0] out_count_ff, out_count_in;
   logic [mf2d_pkg::RW-1:0] out_row_ff, out_row_in;
   logic [mf2d_pkg::CW-1:0] out_col_ff, out_col_in;
   logic [mf2d_pkg::AW-1:0] base_ff, base_in;

   logic accept, wr_en, fire, last;
   logic [mf2d_pkg::TW:0] in_plus, out_plus_lag;

   assign cfg        = cfg_ff;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      cfg_hit   = 1'b0;
      if (reset) begin
         width_in  = 11'd1024;
         height_in = 13'd1024;
         mode_in   = 2'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            mf2d_pkg::CSR_WIDTH: begin
               width_in = csr_data[10:0];
               cfg_hit  = 1'b1;
            end
            mf2d_pkg::CSR_HEIGHT: begin
               height_in = csr_data;
               cfg_hit   = 1'b1;
            end
            mf2d_pkg::CSR_MODE: begin
               mode_in = csr_data[1:0];
               cfg_hit = 1'b1;
            end
            default: begin
            end
         endcase
      end
      // derived values follow the next register contents, so they are registered together with them
      cfg_in.w     = mf2d_pkg::eff_width(width_in);
      cfg_in.h     = mf2d_pkg::eff_height(height_in);
      cfg_in.half  = mf2d_pkg::eff_half(mode_in);
      cfg_in.total = mf2d_pkg::TW'(cfg_in.w * cfg_in.h);
      cfg_in.lag   = mf2d_pkg::LW'(cfg_in.half * cfg_in.w + cfg_in.half);
   end

   always_comb begin
      wr_en        = accept && !action && (in_count_ff < cfg_ff.total);
      in_plus      = {1'b0, in_count_ff} + 1'b1;
      out_plus_lag = {1'b0, out_count_ff} + (mf2d_pkg::TW+1)'(cfg_ff.lag);
      fire = accept && (out_count_ff < cfg_ff.total) &&
             (wr_en ? (in_plus > out_plus_lag) : (in_count_ff >= cfg_ff.total));
      last = ((out_count_ff + 1'b1) == cfg_ff.total);

      // store addresses run on across frames, so a new frame never overwrites
      // pixels that queued jobs of the previous frame still read
      store_wr.en   = wr_en;
      store_wr.addr = base_ff + in_count_ff[mf2d_pkg::AW-1:0];
      store_wr.data = pixel;

      q_push     = fire;
      q_job.q    = base_ff + out_count_ff[mf2d_pkg::AW-1:0];
      q_job.r    = out_row_ff;
      q_job.c    = out_col_ff;
      q_job.last = last;

      in_count_in  = wr_en ? in_plus[mf2d_pkg::TW-1:0] : in_count_ff;
      out_count_in = out_count_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      base_in      = base_ff;
      if (fire) begin
         if (last) begin
            // frame done: next item starts a new frame
            in_count_in  = '0;
            out_count_in = '0;
            out_row_in   = '0;
            out_col_in   = '0;
            base_in      = base_ff + cfg_ff.total[mf2d_pkg::AW-1:0];
         end else begin
            out_count_in = out_count_ff + 1'b1;
            if (mf2d_pkg::WW'(out_col_ff) == cfg_ff.w - 1'b1) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      width_ff  <= width_in;
      height_ff <= height_in;
      mode_ff   <= mode_in;
      cfg_ff    <= cfg_in;
      if (reset || cfg_hit) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         base_ff      <= '0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         base_ff      <= base_in;
      end
   end

endmodule

FILE: rtl/mf2d_back.sv
// ----------------------------------------------------------------------------
// mf2d_back
// Line store and median engine: per job, eight radix passes over the
// window, one store read per cycle, then the result register.
// ----------------------------------------------------------------------------
module mf2d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mf2d_pkg::cfg_type      cfg,
   input  mf2d_pkg::store_wr_type store_wr,
   input  logic                   q_empty,
   input  mf2d_pkg::job_type      q_job,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             median,
   output logic                   last_of_frame
);

   logic [7:0] store [2**mf2d_pkg::AW];

   mf2d_pkg::back_state_type state_ff, state_in;
   mf2d_pkg::job_type job_ff, job_in;

   logic [mf2d_pkg::AW-1:0]         addr_ff, addr_in;
   logic signed [mf2d_pkg::NYW-1:0] ny_ff, ny_in;
   logic signed [mf2d_pkg::NXW-1:0] nx_ff, nx_in;
   logic signed [mf2d_pkg::NXW-1:0] nx_start;
   logic [mf2d_pkg::DXW-1:0]        dx_ff, dx_in;
   logic [mf2d_pkg::NW-1:0]         cell_ff, cell_in;
   logic [2:0]                      bit_ff, bit_in;
   logic [7:0]                      prefix_ff, prefix_in;
   logic [mf2d_pkg::NW-1:0]         k_ff, k_in;
   logic [mf2d_pkg::NW-1:0]         cnt_ff, cnt_in;
   logic                            rd_valid_ff, inb_ff, inb;
   logic [7:0]                      rd_data_ff;
   logic [7:0]                      val, mask;
   logic                            match;
   logic [mf2d_pkg::NW-1:0]         ncells;
   logic [mf2d_pkg::DXW-1:0]        side_m1;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_median_ff, out_median_in;
   logic       out_last_ff, out_last_in;

   assign rsp_tvalid    = out_valid_ff;
   assign median        = out_median_ff;
   assign last_of_frame = out_last_ff;

   assign ncells  = mf2d_pkg::win_cells(cfg.half);
   assign side_m1 = mf2d_pkg::DXW'({cfg.half, 1'b0});

   // window bounds of the cell being read
   assign inb = (ny_ff >= 0) && (ny_ff < $signed({1'b0, cfg.h})) &&
                (nx_ff >= 0) &&
                (nx_ff < $signed(mf2d_pkg::NXW'(cfg.w)));

   always_comb begin
      val   = inb_ff ? rd_data_ff : 8'd0;
      mask  = 8'hFF << ({1'b0, bit_ff} + 4'd1);
      match = (((val ^ prefix_ff) & mask) == 8'd0) && !val[bit_ff];
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      addr_in       = addr_ff;
      ny_in         = ny_ff;
      nx_in         = nx_ff;
      dx_in         = dx_ff;
      cell_in       = cell_ff;
      bit_in        = bit_ff;
      prefix_in     = prefix_ff;
      k_in          = k_ff;
      cnt_in        = (rd_valid_ff && match) ? cnt_ff + 1'b1 : cnt_ff;
      q_pop         = 1'b0;
      out_valid_in  = rsp_tready ? 1'b0 : out_valid_ff;
      out_median_in = out_median_ff;
      out_last_in   = out_last_ff;
      nx_start      = $signed({2'b00, job_ff.c}) -
                      $signed({{(mf2d_pkg::NXW-mf2d_pkg::HW){1'b0}}, cfg.half});

      unique case (state_ff)
         mf2d_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               job_in    = q_job;
               addr_in   = q_job.q - mf2d_pkg::AW'(cfg.lag);
               ny_in     = $signed({2'b00, q_job.r}) -
                           $signed({{(mf2d_pkg::NYW-mf2d_pkg::HW){1'b0}}, cfg.half});
               nx_in     = $signed({2'b00, q_job.c}) -
                           $signed({{(mf2d_pkg::NXW-mf2d_pkg::HW){1'b0}}, cfg.half});
               dx_in     = '0;
               cell_in   = '0;
               bit_in    = 3'd7;
               prefix_in = 8'd0;
               k_in      = ncells >> 1;
               cnt_in    = '0;
               state_in  = mf2d_pkg::BK_SCAN;
            end
         end
         mf2d_pkg::BK_SCAN: begin
            cell_in = cell_ff + 1'b1;
            if (dx_ff == side_m1) begin
               dx_in   = '0;
               nx_in   = nx_start;
               ny_in   = ny_ff + 1'b1;
               addr_in = addr_ff + mf2d_pkg::AW'(cfg.w) -
                         mf2d_pkg::AW'({cfg.half, 1'b0});
            end else begin
               dx_in   = dx_ff + 1'b1;
               nx_in   = nx_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (cell_ff == ncells - 1'b1) begin
               state_in = mf2d_pkg::BK_TAIL;
            end
         end
         mf2d_pkg::BK_TAIL: begin
            // last read of the pass is counted here
            state_in = mf2d_pkg::BK_DECIDE;
         end
         mf2d_pkg::BK_DECIDE: begin
            if (k_ff >= cnt_ff) begin
               prefix_in[bit_ff] = 1'b1;
               k_in = k_ff - cnt_ff;
            end
            cnt_in = '0;
            if (bit_ff == 3'd0) begin
               state_in = mf2d_pkg::BK_DONE;
            end else begin
               bit_in   = bit_ff - 1'b1;
               addr_in  = job_ff.q - mf2d_pkg::AW'(cfg.lag);
               ny_in    = $signed({2'b00, job_ff.r}) -
                          $signed({{(mf2d_pkg::NYW-mf2d_pkg::HW){1'b0}}, cfg.half});
               nx_in    = nx_start;
               dx_in    = '0;
               cell_in  = '0;
               state_in = mf2d_pkg::BK_SCAN;
            end
         end
         mf2d_pkg::BK_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in  = 1'b1;
               out_median_in = prefix_ff;
               out_last_in   = job_ff.last;
               state_in      = mf2d_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mf2d_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mf2d_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rd_valid_ff  <= (state_ff == mf2d_pkg::BK_SCAN);
      end
      job_ff        <= job_in;
      addr_ff       <= addr_in;
      ny_ff         <= ny_in;
      nx_ff         <= nx_in;
      dx_ff         <= dx_in;
      cell_ff       <= cell_in;
      bit_ff        <= bit_in;
      prefix_ff     <= prefix_in;
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      inb_ff        <= inb;
      out_median_ff <= out_median_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store[addr_ff];
   end

endmodule

FILE: rtl/median_filter_2d_core.sv
// ----------------------------------------------------------------------------
// median_filter_2d_core
// Zero-padded 2-D median filter (3x3, 5x5, 7x7) over an 8-bit raster frame.
// ----------------------------------------------------------------------------
// The front takes one item per cycle as long as its four-entry job queue has
// room; pixels go straight into the line store. Each result is ranked in the
// back by eight radix passes over the n-cell window (n = 9, 25 or 49), one
// line store read per cycle while scanning; the back finishes one result
// before it takes the next job, and that sets the sustained rate once the
// queue is full. The line store needs no clearing after reset.
// Configuration takes effect on the next cycle and restarts the frame.
module median_filter_2d_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] median
   output logic        rsp_tlast
);

   mf2d_pkg::cfg_type      cfg;
   mf2d_pkg::store_wr_type store_wr;
   mf2d_pkg::job_type      push_job, pop_job;
   logic q_push, q_full, q_pop, q_empty;

   mf2d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .pixel      (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job),
      .store_wr   (store_wr),
      .cfg        (cfg)
   );

   mf2d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   mf2d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .store_wr      (store_wr),
      .q_empty       (q_empty),
      .q_job         (pop_job),
      .q_pop         (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .median        (rsp_tdata),
      .last_of_frame (rsp_tlast)
   );

endmodule
